// ===== rtl/core/lphm_pkg.sv =====
package lphm_pkg;

    // Table geometry. The slot count must be a power of two.
    localparam int SLOTS   = 256;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KEY_W   = 32;
    localparam int HASH_W  = 32;
    localparam int VAL_W   = 32;
    localparam int LIMIT_W = 8;

    localparam logic [SLOT_W-1:0]  IDX_ONE     = SLOT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0]   SLOTS_CNT   = CNT_W'(SLOTS);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

    // Command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key_id;
        logic [HASH_W-1:0]  key_hash;
        logic [VAL_W-1:0]   value_in;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   value_out;
    } t_out_item;

    // One stored slot: key and value share a memory word.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_slot;

    // Status from the probe sequencer to the top level.
    typedef struct packed {
        logic               ready;
        logic               res_valid;
        t_out_item          res;
    } t_ctrl_stat;

endpackage

// ===== rtl/core/lphm_ram.sv =====
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lphm_ctrl.sv =====
module lphm_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  lphm_pkg::t_in_item              i_in,
    input  logic [lphm_pkg::LIMIT_W-1:0]    i_limit,
    input  logic                            i_take,
    output lphm_pkg::t_ctrl_stat            o_stat
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_cmd, n_cmd;
    logic [lphm_pkg::KEY_W-1:0]      r_key, n_key;
    logic [lphm_pkg::VAL_W-1:0]      r_val, n_val;
    logic [lphm_pkg::SLOT_W-1:0]     r_idx, n_idx;
    logic [lphm_pkg::CNT_W-1:0]      r_visits, n_visits;
    logic                            r_cmp_vld, n_cmp_vld;
    logic [lphm_pkg::SLOT_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                            r_cmp_occ, n_cmp_occ;
    logic [lphm_pkg::CNT_W-1:0]      r_count, n_count;
    logic [lphm_pkg::SLOTS-1:0]      r_valid;
    lphm_pkg::t_status               r_res_status, n_res_status;
    logic [lphm_pkg::VAL_W-1:0]      r_res_value, n_res_value;

    logic                            ram_we;
    lphm_pkg::t_slot                 ram_wdata;
    lphm_pkg::t_slot                 ram_rdata;
    logic                            issue;
    logic                            hit_match;
    logic                            hit_empty;
    logic                            probe_done;
    logic                            table_full;

    // Key/value store, read one slot per cycle.
    lphm_ram #(
        .WIDTH($bits(lphm_pkg::t_slot)),
        .DEPTH(lphm_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmp_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = '{key: r_key, value: r_val};

    // Probe compare: the slot read last cycle is checked against the key.
    assign issue      = (r_visits != lphm_pkg::SLOTS_CNT);
    assign hit_match  = r_cmp_occ && (ram_rdata.key == r_key);
    assign hit_empty  = !r_cmp_occ;
    assign probe_done = r_cmp_vld && (hit_match || hit_empty || !issue);

    // An insert is refused up front once the limit or the capacity is reached.
    assign table_full = (32'(r_count) >= 32'(i_limit)) || (r_count >= lphm_pkg::SLOTS_CNT);

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_visits     = r_visits;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_occ    = r_cmp_occ;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        ram_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_cmd       = i_in.cmd;
                    n_key       = i_in.key_id;
                    n_val       = i_in.value_in;
                    n_idx       = i_in.key_hash[lphm_pkg::SLOT_W-1:0];
                    n_visits    = '0;
                    n_cmp_vld   = 1'b0;
                    n_res_value = '0;
                    if (i_in.cmd == lphm_pkg::CMD_INSERT && table_full) begin
                        n_res_status = lphm_pkg::ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (probe_done) begin
                    n_res_value = '0;
                    n_state     = S_DONE;
                    if (hit_match) begin
                        if (r_cmd == lphm_pkg::CMD_LOOKUP) begin
                            n_res_status = lphm_pkg::ST_OK;
                            n_res_value  = ram_rdata.value;
                        end else begin
                            n_res_status = lphm_pkg::ST_MISS;
                        end
                    end else if (hit_empty) begin
                        if (r_cmd == lphm_pkg::CMD_LOOKUP) begin
                            n_res_status = lphm_pkg::ST_MISS;
                        end else begin
                            n_res_status = lphm_pkg::ST_OK;
                            ram_we       = 1'b1;
                            n_count      = r_count + lphm_pkg::CNT_ONE;
                        end
                    end else begin
                        // Every slot visited without a match or a hole.
                        if (r_cmd == lphm_pkg::CMD_LOOKUP) begin
                            n_res_status = lphm_pkg::ST_MISS;
                        end else begin
                            n_res_status = lphm_pkg::ST_FULL;
                        end
                    end
                end else begin
                    n_cmp_vld = issue;
                    n_cmp_idx = r_idx;
                    n_cmp_occ = r_valid[r_idx];
                    if (issue) begin
                        n_idx    = r_idx + lphm_pkg::IDX_ONE;
                        n_visits = r_visits + lphm_pkg::CNT_ONE;
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and slot occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_count   <= n_count;
            if (ram_we) begin
                r_valid[r_cmp_idx] <= 1'b1;
            end
        end
    end

    // Item payload and probe position.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_visits     <= n_visits;
        r_cmp_idx    <= n_cmp_idx;
        r_cmp_occ    <= n_cmp_occ;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
    end

    assign o_stat.ready         = (r_state == S_IDLE);
    assign o_stat.res_valid     = (r_state == S_DONE);
    assign o_stat.res.status    = r_res_status;
    assign o_stat.res.value_out = r_res_value;

endmodule

// ===== rtl/core/linear_probe_hash_map.sv =====
// Open-addressing key/value map with linear probing.
// Input channel (i_in_valid, o_in_stall, i_in_data): a transaction carries a
// lookup or an insert with the key identity, its hash and the insert value.
// A transaction is taken only while the probe sequencer is idle.
// Output channel (o_out_valid, i_out_stall, o_out_data): one result per
// input transaction, in order, with status and the looked-up value.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data): writes the
// entry limit; it is always ready.
// Timing: each item passes through the idle, probe and done states, and the
// next input transaction is taken only once the result has left the
// sequencer. An insert refused by the entry limit goes from idle straight to
// done without probing. The slot memory has one read port and is read once
// a cycle.
// Reset empties every slot through per-slot valid flops, clears the entry
// count and sets the limit to 192; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its next result until that register frees up.
module linear_probe_hash_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lphm_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lphm_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lphm_pkg::LIMIT_W-1:0]    i_cfg_data
);

    logic [lphm_pkg::LIMIT_W-1:0] r_limit;
    logic                         r_out_valid, n_out_valid;
    lphm_pkg::t_out_item          r_out_data;
    lphm_pkg::t_ctrl_stat         ctrl_stat;
    logic                         in_accept;
    logic                         out_free;
    logic                         take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !ctrl_stat.ready;
    assign in_accept   = i_in_valid && ctrl_stat.ready;

    // Probe sequencer with the slot store.
    lphm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_in     (i_in_data),
        .i_limit  (r_limit),
        .i_take   (take),
        .o_stat   (ctrl_stat)
    );

    // Entry limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lphm_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Output register: loads when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = ctrl_stat.res_valid && out_free;

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= ctrl_stat.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // While the input side is open, no result may be pending in the sequencer.
    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !ctrl_stat.res_valid)
        else $error("input ready while a result is pending");

    // An accepted transaction closes the input side on the next cycle.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input still open after a transaction");

    // Only a successful lookup carries a nonzero value.
    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != lphm_pkg::ST_OK) |->
            (o_out_data.value_out == '0))
        else $error("nonzero value on a failed result");

    // A result waiting in the sequencer is moved only into a free register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !take)
        else $error("output register overwritten while stalled");
`endif

endmodule

// ===== tb/linear_probe_hash_map_tb.sv =====
`timescale 1ns / 100ps

module linear_probe_hash_map_tb;

    localparam int CLK_HALF_NS = 2;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam longint RUN_LIMIT_NS = 64'd12_000_000;
    localparam int MAX_REPORTS = 10;

    // Local copies of the table geometry.
    localparam int SLOTS   = lphm_pkg::SLOTS;
    localparam int SLOT_W  = lphm_pkg::SLOT_W;
    localparam int CNT_W   = lphm_pkg::CNT_W;
    localparam int KEY_W   = lphm_pkg::KEY_W;
    localparam int HASH_W  = lphm_pkg::HASH_W;
    localparam int VAL_W   = lphm_pkg::VAL_W;
    localparam int LIMIT_W = lphm_pkg::LIMIT_W;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
    } t_key_ref;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    lphm_pkg::t_in_item     i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    lphm_pkg::t_out_item    o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [LIMIT_W-1:0]     i_cfg_data = '0;

    // Shadow copy of the table and its fill state.
    logic                map_valid [SLOTS];
    logic [KEY_W-1:0]    map_key [SLOTS];
    logic [VAL_W-1:0]    map_value [SLOTS];
    logic [CNT_W-1:0]    map_count;
    logic [LIMIT_W-1:0]  map_limit;

    lphm_pkg::t_in_item  pending_ops [$];
    lphm_pkg::t_out_item results_due [$];
    t_key_ref            key_pool [$];
    int                  err_count = 0;
    int                  gap_left = 0;
    int                  stall_left = 0;
    bit                  quiet = 1'b0;

    linear_probe_hash_map u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Apply one lookup or insert to the shadow table and return its result.
    function automatic lphm_pkg::t_out_item apply_map_op(input lphm_pkg::t_in_item op);
        lphm_pkg::t_out_item res;
        logic [SLOT_W-1:0]   idx;
        int                  pos;
        res.status = lphm_pkg::ST_MISS;
        res.value_out = '0;
        pos = -1;
        // The capacity check comes ahead of any probing.
        if (op.cmd == lphm_pkg::CMD_INSERT &&
            ((map_count + lphm_pkg::CNT_ONE) > CNT_W'(map_limit) ||
             map_count >= lphm_pkg::SLOTS_CNT)) begin
            res.status = lphm_pkg::ST_FULL;
            return res;
        end
        idx = op.key_hash[SLOT_W-1:0];
        for (int n = 0; n < SLOTS && pos < 0; n++) begin
            if (!map_valid[idx] || map_key[idx] == op.key_id) begin
                pos = int'(idx);
            end else begin
                idx = idx + lphm_pkg::IDX_ONE;
            end
        end
        if (op.cmd == lphm_pkg::CMD_LOOKUP) begin
            if (pos >= 0 && map_valid[pos]) begin
                res.status = lphm_pkg::ST_OK;
                res.value_out = map_value[pos];
            end
        end else if (pos < 0) begin
            res.status = lphm_pkg::ST_FULL;
        end else if (map_valid[pos]) begin
            res.status = lphm_pkg::ST_MISS;
        end else begin
            map_valid[pos] = 1'b1;
            map_key[pos] = op.key_id;
            map_value[pos] = op.value_in;
            map_count = map_count + lphm_pkg::CNT_ONE;
            res.status = lphm_pkg::ST_OK;
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Put a share of the start slots near the top of the table so that probes wrap.
    function automatic logic [HASH_W-1:0] gen_hash();
        logic [HASH_W-1:0] h;
        h = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            h[SLOT_W-1:0] = SLOT_W'(SLOTS - 4 + $urandom_range(0, 7));
        end
        return h;
    endfunction

    task automatic note_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0.1f ns: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what,
                     want, got);
        end
    endtask

    task automatic queue_op(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] val);
        lphm_pkg::t_in_item op;
        op.cmd = cmd;
        op.key_id = key;
        op.key_hash = hash;
        op.value_in = val;
        pending_ops.push_back(op);
    endtask

    // Wait until every queued transaction is sent and every result is back.
    task automatic drain();
        while (pending_ops.size() != 0 || i_in_valid || results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        map_limit = lim;
        @(negedge i_clk);
    endtask

    // Mostly well-formed traffic on known keys, with some noise mixed in.
    task automatic run_traffic(input int n_ops, input bit calm);
        t_key_ref pick;
        int       r;
        quiet = calm;
        @(negedge i_clk);
        for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(0, 99);
            if (key_pool.size() != 0) begin
                pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            if (r < 40 || key_pool.size() == 0) begin
                pick.key = $urandom;
                pick.hash = gen_hash();
                key_pool.push_back(pick);
                queue_op(lphm_pkg::CMD_INSERT, pick.key, pick.hash, $urandom);
            end else if (r < 75) begin
                queue_op(lphm_pkg::CMD_LOOKUP, pick.key, pick.hash, $urandom);
            end else if (r < 85) begin
                queue_op(lphm_pkg::CMD_INSERT, pick.key, pick.hash, $urandom);
            end else if (r < 95) begin
                queue_op(lphm_pkg::CMD_LOOKUP, $urandom, gen_hash(), $urandom);
            end else begin
                queue_op(lphm_pkg::CMD_LOOKUP, pick.key, gen_hash(), $urandom);
            end
        end
    endtask

    // Driver: present queued transactions, predict each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                results_due.push_back(apply_map_op(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_ops.pop_front();
                    gap_left <= quiet ? 0 : idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction and stall the output at random.
    always @(posedge i_clk) begin
        lphm_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    note_mismatch("unexpected result, value_out", '0, o_out_data.value_out);
                end else begin
                    want = results_due.pop_front();
                    if (o_out_data.status !== want.status) begin
                        note_mismatch("status", VAL_W'(want.status),
                                      VAL_W'(o_out_data.status));
                    end
                    if (o_out_data.value_out !== want.value_out) begin
                        note_mismatch("value_out", want.value_out, o_out_data.value_out);
                    end
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                stall_left <= idle_len();
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            map_valid[s] = 1'b0;
            map_key[s] = '0;
            map_value[s] = '0;
        end
        map_count = '0;
        map_limit = lphm_pkg::LIMIT_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed checks at the reset limit: empty table, duplicates, wrap-around.
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_1234);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000);
        queue_op(lphm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0001, 32'h0000_00FF, 32'hA5A5_A5A5);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0003, 32'h0000_00FF, 32'h0000_0000);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555);
        drain();

        // A limit of zero refuses every insert, present keys included.
        write_limit(8'd0);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0005, 32'h0000_0005, 32'h0000_0001);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0002);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
        drain();

        // Room for exactly one more entry.
        write_limit(8'd4);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0005, 32'h8000_0005, 32'h5A5A_5A5A);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0006, 32'h0000_0006, 32'h0000_0006);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0005, 32'h0000_0005, 32'h0000_0007);
        drain();

        // Limit lowered below the stored count: entries stay, inserts are refused.
        write_limit(8'd1);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0007, 32'h0000_0007, 32'h0000_0007);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0005, 32'h8000_0005, 32'h0000_0000);
        drain();

        write_limit(8'd255);
        queue_op(lphm_pkg::CMD_INSERT, 32'h0000_0008, 32'hFFFF_FFFE, 32'hDEAD_BEEF);
        queue_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0008, 32'hFFFF_FFFE, 32'h0000_0000);
        drain();

        // Random phases over a range of limits, ending with the table nearly full.
        write_limit(8'd48);
        run_traffic(400, 1'b0);
        drain();

        write_limit(8'd1);
        run_traffic(100, 1'b0);
        drain();

        // The sender holds off mid-phase until all results are back.
        write_limit(8'd128);
        run_traffic(200, 1'b0);
        drain();
        run_traffic(200, 1'b1);
        drain();

        write_limit(LIMIT_W'($urandom_range(129, 254)));
        run_traffic(300, 1'b0);
        drain();

        write_limit(8'd0);
        run_traffic(100, 1'b0);
        drain();

        write_limit(8'd255);
        run_traffic(550, 1'b0);
        drain();

        if (err_count == 0 && results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
